[rtl/grhm_pkg.sv]
// ----------------------------------------------------------------------------
// grhm_pkg
// Shared types, codes and constants of the gain reduction history meter.
// ----------------------------------------------------------------------------
package grhm_pkg;

  localparam int HIST_DEPTH_DEF  = 512;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int QUEUE_DEPTH     = 2;

  localparam int ACTION_W   = 2;
  localparam int AGE_W      = 9;
  localparam int LEVEL_W    = 15;
  localparam int OUT_DATA_W = 16;
  localparam int SPB_W      = 16;
  localparam int CHAN_W     = 2;
  localparam int THR_W      = 23;
  localparam int PW_W       = 10;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int MANT_W     = 16;
  localparam int SCALE_W    = 18;

  // 6.0206 * 128 in Q8 and the -80 dB floor in 1/128 dB
  localparam logic [SCALE_W-1:0] DB_SCALE = 18'd197283;
  localparam int                 DB_FLOOR = 10240;

  localparam logic [SPB_W-1:0]  SPB_RESET  = 16'd48;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;
  localparam logic [CHAN_W-1:0] CHAN_MONO  = 2'd1;
  localparam logic [THR_W-1:0]  THR_RESET  = 23'd83886;
  localparam logic [PW_W-1:0]   PW_RESET   = 10'd100;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_READ   = 2'd1,
    ACT_PEAK   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_READ,
    CMD_PEAK,
    CMD_NOP
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES_PER_BIN   = 2'd0,
    CFG_CHANNEL_COUNT     = 2'd1,
    CFG_AUDIBLE_THRESHOLD = 2'd2,
    CFG_PEAK_WINDOW       = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NORM,
    BK_LOG,
    BK_MUL,
    BK_CLOSE,
    BK_AGE,
    BK_RD_ADDR,
    BK_RD_DATA,
    BK_PEAK,
    BK_REPLY
  } back_state_e;

  typedef struct packed {
    logic [SPB_W-1:0]  samples_per_bin;
    logic [CHAN_W-1:0] channel_count;
    logic [THR_W-1:0]  audible_threshold;
    logic [PW_W-1:0]   peak_window;
  } cfg_t;

  typedef logic [MANT_W-1:0] mant_table_t [64];

  // q16 log2 of (64+i)/64 by repeated squaring in q30, truncating
  function automatic mant_table_t build_mant_table();
    mant_table_t t;
    logic [63:0] m;
    logic [MANT_W-1:0] frac;
    for (int i = 0; i < 64; i++) begin
      m = 64'(64 + i) << 24;
      frac = '0;
      for (int b = MANT_W - 1; b >= 0; b--) begin
        m = (m * m) >> 30;
        if (m >= 64'h8000_0000) begin
          m = m >> 1;
          frac[b] = 1'b1;
        end
      end
      t[i] = frac;
    end
    return t;
  endfunction

  localparam mant_table_t MANT_TABLE = build_mant_table();

endpackage

[rtl/grhm_ram.sv]
// ----------------------------------------------------------------------------
// grhm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module grhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/grhm_fifo.sv]
// ----------------------------------------------------------------------------
// grhm_fifo
// Small command queue between the accepting front and the executing back.
// ----------------------------------------------------------------------------
module grhm_fifo import grhm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/grhm_front.sv]
// ----------------------------------------------------------------------------
// grhm_front
// Accepts input words, decodes the action and folds the channels into
// one pre and one post magnitude per sample.
// ----------------------------------------------------------------------------
module grhm_front import grhm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ACTION_W-1:0]    action_i,
  input  logic [SAMPLE_BITS-1:0] pre_left_i,
  input  logic [SAMPLE_BITS-1:0] pre_right_i,
  input  logic [SAMPLE_BITS-1:0] post_left_i,
  input  logic [SAMPLE_BITS-1:0] post_right_i,
  input  logic [AGE_W-1:0]       age_i,
  input  logic [CHAN_W-1:0]      channel_count_i,
  input  logic                   queue_full_i,
  output logic                   push_o,
  output cmd_e                   kind_o,
  output logic [SAMPLE_BITS-2:0] pre_mag_o,
  output logic [SAMPLE_BITS-2:0] post_mag_o,
  output logic [AGE_W-1:0]       age_o
);

  localparam int MagW = SAMPLE_BITS - 1;

  // most negative code saturates to the largest positive magnitude
  function automatic logic [MagW-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS-1:0] neg_v;
    neg_v = -v;
    if (!v[SAMPLE_BITS-1]) begin
      return v[MagW-1:0];
    end else if (v == {1'b1, {MagW{1'b0}}}) begin
      return '1;
    end else begin
      return neg_v[MagW-1:0];
    end
  endfunction

  logic [MagW-1:0] pre_l, pre_r, post_l, post_r;
  logic            stereo;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;
  assign age_o      = age_i;

  assign pre_l  = magnitude(pre_left_i);
  assign pre_r  = magnitude(pre_right_i);
  assign post_l = magnitude(post_left_i);
  assign post_r = magnitude(post_right_i);
  assign stereo = (channel_count_i != CHAN_MONO);

  always_comb begin
    pre_mag_o  = pre_l;
    post_mag_o = post_l;
    if (stereo) begin
      if (pre_r > pre_l) begin
        pre_mag_o = pre_r;
      end
      if (post_r > post_l) begin
        post_mag_o = post_r;
      end
    end
  end

  always_comb begin
    unique case (action_e'(action_i))
      ACT_SAMPLE: kind_o = CMD_SAMPLE;
      ACT_READ:   kind_o = CMD_READ;
      ACT_PEAK:   kind_o = CMD_PEAK;
      default:    kind_o = CMD_NOP;
    endcase
  end

endmodule

[rtl/grhm_back.sv]
// ----------------------------------------------------------------------------
// grhm_back
// Executes queued commands: bin peak tracking, log2 based gain reduction,
// history ring writes, history reads, recent peak scans and the result
// register.
// ----------------------------------------------------------------------------
module grhm_back import grhm_pkg::*; #(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   cmd_empty_i,
  output logic                   cmd_pop_o,
  input  cmd_e                   cmd_kind_i,
  input  logic [SAMPLE_BITS-2:0] cmd_pre_i,
  input  logic [SAMPLE_BITS-2:0] cmd_post_i,
  input  logic [AGE_W-1:0]       cmd_age_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic                   res_done_o,
  output logic [LEVEL_W-1:0]     res_level_o
);

  localparam int MagW  = SAMPLE_BITS - 1;
  localparam int AddrW = $clog2(HISTORY_DEPTH);
  localparam int FillW = $clog2(HISTORY_DEPTH + 1);
  localparam int PosW  = $clog2(MagW);
  localparam int LogW  = PosW + MANT_W;
  localparam int ProdW = LogW + SCALE_W;
  localparam int RndW  = ProdW + 1;
  localparam int QW    = RndW - 24;
  localparam int ModW  = (FillW > AGE_W) ? FillW : AGE_W;
  localparam int CmpW  = (FillW > PW_W) ? FillW : PW_W;
  localparam int ThrW  = (MagW > THR_W) ? MagW : THR_W;
  localparam int ExtW  = AddrW + 2;

  function automatic logic [PosW-1:0] lead_pos(input logic [MagW-1:0] v);
    logic [PosW-1:0] p;
    p = '0;
    for (int i = 0; i < MagW; i++) begin
      if (v[i]) begin
        p = PosW'(i);
      end
    end
    return p;
  endfunction

  back_state_e state_q, state_d;

  logic [SPB_W-1:0]   cnt_q, cnt_d;
  logic [MagW-1:0]    peak_pre_q, peak_pre_d, peak_post_q, peak_post_d;
  logic [AddrW-1:0]   wp_q, wp_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               out_valid_q, out_valid_d;

  logic [MagW-1:0]    fin_pre_q, fin_pre_d, fin_post_q, fin_post_d;
  logic [PosW-1:0]    pos_pre_q, pos_pre_d, pos_post_q, pos_post_d;
  logic               report_q, report_d, post_zero_q, post_zero_d;
  logic [LogW-1:0]    diff_q, diff_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [ModW-1:0]    age_q, age_d;
  logic               rd_ok_q, rd_ok_d;
  logic [FillW-1:0]   scan_cnt_q, scan_cnt_d;
  logic [AddrW-1:0]   scan_ptr_q, scan_ptr_d;
  logic               scan_pend_q, scan_pend_d;
  logic signed [LEVEL_W-1:0] scan_min_q, scan_min_d;
  logic               res_done_q, res_done_d;
  logic [LEVEL_W-1:0] res_level_q, res_level_d;
  logic               out_done_q, out_done_d;
  logic [LEVEL_W-1:0] out_level_q, out_level_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_raddr;
  logic [LEVEL_W-1:0] ram_wdata, ram_rdata;

  // sample bookkeeping
  logic [SPB_W-1:0] cnt_next, limit;
  logic             bin_close;
  logic [MagW-1:0]  pre_max, post_max;

  // log and dB path
  logic [MagW-1:0]  norm_pre, norm_post;
  logic [LogW-1:0]  log_pre, log_post;
  logic [RndW-1:0]  rounded;
  logic [QW-1:0]    q_mag;
  logic [LEVEL_W-1:0] close_level;

  // history addressing
  logic [ExtW-1:0]  rd_idx;
  logic [CmpW-1:0]  win;
  logic             scan_issue;
  logic signed [LEVEL_W-1:0] scan_rd;
  logic             out_free;

  assign out_free = !out_valid_q || res_ready_i;

  assign cnt_next  = cnt_q + SPB_W'(1);
  assign limit     = (cfg_i.samples_per_bin == '0) ? SPB_W'(1) : cfg_i.samples_per_bin;
  assign bin_close = (cnt_next >= limit) || (cnt_next == '0);
  assign pre_max   = (cmd_pre_i > peak_pre_q) ? cmd_pre_i : peak_pre_q;
  assign post_max  = (cmd_post_i > peak_post_q) ? cmd_post_i : peak_post_q;

  // leading one moved to the top bit, the six bits below it index the table
  assign norm_pre  = fin_pre_q << (PosW'(MagW - 1) - pos_pre_q);
  assign norm_post = fin_post_q << (PosW'(MagW - 1) - pos_post_q);
  assign log_pre   = {pos_pre_q, MANT_TABLE[norm_pre[MagW-2 -: 6]]};
  assign log_post  = {pos_post_q, MANT_TABLE[norm_post[MagW-2 -: 6]]};

  assign rounded = RndW'(prod_q) + (RndW'(1) << 23);
  assign q_mag   = rounded[RndW-1:24];

  always_comb begin
    if (!report_q) begin
      close_level = '0;
    end else if (post_zero_q || (q_mag >= QW'(DB_FLOOR))) begin
      close_level = -LEVEL_W'(DB_FLOOR);
    end else begin
      close_level = -LEVEL_W'(q_mag);
    end
  end

  assign rd_idx = ExtW'(wp_q) - ExtW'(age_q[AddrW-1:0]) - ExtW'(1);
  assign win    = (CmpW'(cfg_i.peak_window) < CmpW'(fill_q)) ?
                  CmpW'(cfg_i.peak_window) : CmpW'(fill_q);
  assign scan_issue = (scan_cnt_q != '0);
  assign scan_rd    = $signed(ram_rdata);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_kind_i)
            CMD_SAMPLE: state_d = bin_close ? BK_NORM : BK_REPLY;
            CMD_READ:   state_d = BK_AGE;
            CMD_PEAK:   state_d = BK_PEAK;
            CMD_NOP:    state_d = BK_REPLY;
          endcase
        end
      end
      BK_NORM:    state_d = BK_LOG;
      BK_LOG:     state_d = BK_MUL;
      BK_MUL:     state_d = BK_CLOSE;
      BK_CLOSE:   state_d = BK_REPLY;
      BK_AGE: begin
        if (age_q < ModW'(HISTORY_DEPTH)) begin
          state_d = BK_RD_ADDR;
        end
      end
      BK_RD_ADDR: state_d = BK_RD_DATA;
      BK_RD_DATA: state_d = BK_REPLY;
      BK_PEAK: begin
        if (!scan_issue) begin
          state_d = BK_REPLY;
        end
      end
      BK_REPLY: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default:    state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d       = cnt_q;
    peak_pre_d  = peak_pre_q;
    peak_post_d = peak_post_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !res_ready_i;
    fin_pre_d   = fin_pre_q;
    fin_post_d  = fin_post_q;
    pos_pre_d   = pos_pre_q;
    pos_post_d  = pos_post_q;
    report_d    = report_q;
    post_zero_d = post_zero_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    age_d       = age_q;
    rd_ok_d     = rd_ok_q;
    scan_cnt_d  = scan_cnt_q;
    scan_ptr_d  = scan_ptr_q;
    scan_pend_d = 1'b0;
    scan_min_d  = scan_min_q;
    res_done_d  = res_done_q;
    res_level_d = res_level_q;
    out_done_d  = out_done_q;
    out_level_d = out_level_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = close_level;
    ram_raddr   = scan_ptr_q;

    unique case (state_q)
      BK_IDLE: begin
        res_done_d  = 1'b0;
        res_level_d = '0;
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_kind_i)
            CMD_SAMPLE: begin
              if (bin_close) begin
                fin_pre_d   = pre_max;
                fin_post_d  = post_max;
                peak_pre_d  = '0;
                peak_post_d = '0;
                cnt_d       = '0;
              end else begin
                peak_pre_d  = pre_max;
                peak_post_d = post_max;
                cnt_d       = cnt_next;
              end
            end
            CMD_READ: begin
              age_d = ModW'(cmd_age_i);
            end
            CMD_PEAK: begin
              scan_cnt_d = win[FillW-1:0];
              scan_ptr_d = (wp_q == '0) ? AddrW'(HISTORY_DEPTH - 1) : wp_q - AddrW'(1);
              scan_min_d = '0;
            end
            CMD_NOP: begin
            end
          endcase
        end
      end
      BK_NORM: begin
        pos_pre_d   = lead_pos(fin_pre_q);
        pos_post_d  = lead_pos(fin_post_q);
        report_d    = (ThrW'(fin_pre_q) > ThrW'(cfg_i.audible_threshold)) &&
                      (fin_post_q < fin_pre_q);
        post_zero_d = (fin_post_q == '0);
      end
      BK_LOG: begin
        diff_d = (log_pre >= log_post) ? log_pre - log_post : '0;
      end
      BK_MUL: begin
        prod_d = ProdW'(diff_q) * ProdW'(DB_SCALE);
      end
      BK_CLOSE: begin
        ram_we      = 1'b1;
        wp_d        = (wp_q == AddrW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AddrW'(1);
        fill_d      = (fill_q == FillW'(HISTORY_DEPTH)) ? fill_q : fill_q + FillW'(1);
        res_done_d  = 1'b1;
        res_level_d = close_level;
      end
      BK_AGE: begin
        if (age_q >= ModW'(HISTORY_DEPTH)) begin
          age_d = age_q - ModW'(HISTORY_DEPTH);
        end
      end
      BK_RD_ADDR: begin
        // entries never written read as zero
        rd_ok_d   = (age_q < ModW'(fill_q));
        ram_raddr = rd_idx[ExtW-1] ? rd_idx[AddrW-1:0] + AddrW'(HISTORY_DEPTH)
                                   : rd_idx[AddrW-1:0];
      end
      BK_RD_DATA: begin
        res_level_d = rd_ok_q ? ram_rdata : '0;
      end
      BK_PEAK: begin
        if (scan_issue) begin
          scan_cnt_d  = scan_cnt_q - FillW'(1);
          scan_ptr_d  = (scan_ptr_q == '0) ? AddrW'(HISTORY_DEPTH - 1)
                                           : scan_ptr_q - AddrW'(1);
          scan_pend_d = 1'b1;
        end
        if (scan_pend_q && (scan_rd < scan_min_q)) begin
          scan_min_d = scan_rd;
        end
        if (!scan_issue) begin
          res_level_d = (scan_pend_q && (scan_rd < scan_min_q)) ? scan_rd : scan_min_q;
        end
      end
      BK_REPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_done_d  = res_done_q;
          out_level_d = res_level_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      peak_pre_q  <= '0;
      peak_post_q <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      scan_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      peak_pre_q  <= peak_pre_d;
      peak_post_q <= peak_post_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      scan_pend_q <= scan_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_pre_q   <= fin_pre_d;
    fin_post_q  <= fin_post_d;
    pos_pre_q   <= pos_pre_d;
    pos_post_q  <= pos_post_d;
    report_q    <= report_d;
    post_zero_q <= post_zero_d;
    diff_q      <= diff_d;
    prod_q      <= prod_d;
    age_q       <= age_d;
    rd_ok_q     <= rd_ok_d;
    scan_cnt_q  <= scan_cnt_d;
    scan_ptr_q  <= scan_ptr_d;
    scan_min_q  <= scan_min_d;
    res_done_q  <= res_done_d;
    res_level_q <= res_level_d;
    out_done_q  <= out_done_d;
    out_level_q <= out_level_d;
  end

  grhm_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = out_valid_q;
  assign res_done_o  = out_done_q;
  assign res_level_o = out_level_q;

endmodule

[rtl/gain_reduction_history_meter_core.sv]
// ----------------------------------------------------------------------------
// gain_reduction_history_meter_core
// Gain reduction meter with a per-bin history ring and recent peak query.
// ----------------------------------------------------------------------------
// Every input word produces exactly one result word. A front stage accepts
// words into a two-entry command queue while the back executes them one at
// a time, so input and output stall independently. Back steps per item:
// a sample that does not close a bin goes straight to reply; a sample
// that closes a bin passes normalize, log2 lookup, dB multiply, ring
// write and reply; a history read reduces the age modulo the ring depth,
// then addresses the RAM, takes its data and replies; a recent peak query
// scans n = min(peak_window, bins written so far) entries, one read of the
// history RAM per cycle, then replies. Each reply waits out result stalls.
// The history ring needs no clearing pass: a count of written bins makes
// entries never written read as zero.
module gain_reduction_history_meter_core import grhm_pkg::*; #(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pre_left, pre_right, post_left, post_right, age, zero fill
  input  logic [((4 * SAMPLE_BITS + AGE_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // action
  input  logic [ACTION_W-1:0]   s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // level_db, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // bin_done
  output logic                  m_axis_tuser
);

  localparam int MagW  = SAMPLE_BITS - 1;
  localparam int CmdW  = $bits(cmd_e) + 2 * MagW + AGE_W;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples_per_bin   <= SPB_RESET;
      cfg_q.channel_count     <= CHAN_RESET;
      cfg_q.audible_threshold <= THR_RESET;
      cfg_q.peak_window       <= PW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SAMPLES_PER_BIN:   cfg_q.samples_per_bin   <= cfg_wdata_i[SPB_W-1:0];
        CFG_CHANNEL_COUNT:     cfg_q.channel_count     <= cfg_wdata_i[CHAN_W-1:0];
        CFG_AUDIBLE_THRESHOLD: cfg_q.audible_threshold <= cfg_wdata_i[THR_W-1:0];
        CFG_PEAK_WINDOW:       cfg_q.peak_window       <= cfg_wdata_i[PW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic             push, full, pop, empty;
  cmd_e             front_kind, back_kind;
  logic [MagW-1:0]  front_pre, front_post, back_pre, back_post;
  logic [AGE_W-1:0] front_age, back_age;
  logic [CmdW-1:0]  queue_in, queue_out;
  logic [LEVEL_W-1:0] level;

  grhm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .action_i        (s_axis_tuser),
    .pre_left_i      (s_axis_tdata[0 * SAMPLE_BITS +: SAMPLE_BITS]),
    .pre_right_i     (s_axis_tdata[1 * SAMPLE_BITS +: SAMPLE_BITS]),
    .post_left_i     (s_axis_tdata[2 * SAMPLE_BITS +: SAMPLE_BITS]),
    .post_right_i    (s_axis_tdata[3 * SAMPLE_BITS +: SAMPLE_BITS]),
    .age_i           (s_axis_tdata[4 * SAMPLE_BITS +: AGE_W]),
    .channel_count_i (cfg_q.channel_count),
    .queue_full_i    (full),
    .push_o          (push),
    .kind_o          (front_kind),
    .pre_mag_o       (front_pre),
    .post_mag_o      (front_post),
    .age_o           (front_age)
  );

  assign queue_in = {front_kind, front_pre, front_post, front_age};

  grhm_fifo #(
    .WIDTH (CmdW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (queue_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_out),
    .empty_o (empty)
  );

  assign back_kind = cmd_e'(queue_out[CmdW-1 -: $bits(cmd_e)]);
  assign back_pre  = queue_out[AGE_W + MagW +: MagW];
  assign back_post = queue_out[AGE_W +: MagW];
  assign back_age  = queue_out[AGE_W-1:0];

  grhm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (empty),
    .cmd_pop_o   (pop),
    .cmd_kind_i  (back_kind),
    .cmd_pre_i   (back_pre),
    .cmd_post_i  (back_post),
    .cmd_age_i   (back_age),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_done_o  (m_axis_tuser),
    .res_level_o (level)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - LEVEL_W){1'b0}}, level};

  // the back never takes a command from an empty queue
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("command popped from empty queue");

  // a word accepted into an empty queue is there on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && empty) |=> !empty)
    else $error("accepted word lost before the queue");

  // closed bin levels stay within the -80 dB floor and zero
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      ($signed(level) <= 0 && $signed(level) >= -DB_FLOOR))
    else $error("bin level out of range");

endmodule
